// File: design/nfa_pkg.sv
// shared types, constants and helpers for the nfa epsilon simulator
package nfa_pkg;

   localparam int STATES      = 16;
   localparam int TRANSITIONS = 64;

   localparam int OP_W       = 2;
   localparam int IDX_W      = 6;
   localparam int STATE_W    = 4;
   localparam int SYM_W      = 8;
   localparam int TCOUNT_W   = 7;
   localparam int ACTIVE_W   = 16;
   localparam int ADDR_W     = (TRANSITIONS > 1) ? $clog2(TRANSITIONS) : 1;
   localparam int CNT_W      = $clog2(TRANSITIONS + 1);
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 7;

   // item kinds
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_START  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACCEPT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TCOUNT = 2'd2;

   typedef struct packed {
      logic               eps;
      logic [SYM_W-1:0]   sym;
      logic [STATE_W-1:0] dst;
      logic [STATE_W-1:0] src;
   } nfa_entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } nfa_rd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      nfa_entry_type     data;
   } nfa_wr_type;

   typedef struct packed {
      logic              valid;
      logic [STATES-1:0] active;
   } nfa_res_type;

   // one-hot bit of a state, empty for states beyond the automaton
   function automatic logic [STATES-1:0] state_bit(input logic [STATE_W-1:0] s);
      logic [STATES-1:0] v;
      v = '0;
      for (int i = 0; i < STATES; i++) begin
         if (int'(s) == i) v[i] = 1'b1;
      end
      return v;
   endfunction

endpackage

// File: design/nfa_table.sv
// transition table memory, one write and one registered read port
module nfa_table (
   input  logic                  clock,
   input  nfa_pkg::nfa_wr_type   wr,
   input  nfa_pkg::nfa_rd_type   rd,
   output nfa_pkg::nfa_entry_type rd_data
);
   import nfa_pkg::*;

   nfa_entry_type mem [TRANSITIONS];
   nfa_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/nfa_engine.sv
// sequencer that walks the table for symbol moves and epsilon passes
module nfa_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nfa_pkg::OP_W-1:0]      req_op,
   input  logic [nfa_pkg::IDX_W-1:0]     req_index,
   input  nfa_pkg::nfa_entry_type        req_entry,
   input  logic [nfa_pkg::STATE_W-1:0]   start_state,
   input  logic [nfa_pkg::CNT_W-1:0]     valid_count,
   output nfa_pkg::nfa_wr_type           wr,
   output nfa_pkg::nfa_rd_type           rd,
   input  nfa_pkg::nfa_entry_type        rd_data,
   output nfa_pkg::nfa_res_type          res,
   input  logic                          res_ready
);
   import nfa_pkg::*;

   typedef enum logic [1:0] {IDLE, MOVE, EPS, RESULT} state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rd_vld_ff;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic [STATES-1:0] set_ff, set_in;
   logic [STATES-1:0] next_ff, next_in;
   logic              changed_ff, changed_in;
   logic [STATES-1:0] active_ff, active_in;
   logic              issue;
   logic              pass_end;
   logic              src_hit;
   logic [STATES-1:0] dst_bit;

   assign issue    = (cnt_ff < valid_count);
   assign pass_end = !issue && !rd_vld_ff;
   assign src_hit  = |(set_ff & state_bit(rd_data.src));
   assign dst_bit  = state_bit(rd_data.dst);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      sym_in     = sym_ff;
      set_in     = set_ff;
      next_in    = next_ff;
      changed_in = changed_ff;
      active_in  = active_ff;
      req_ready  = (state_ff == IDLE);
      rd.en      = 1'b0;
      rd.addr    = cnt_ff[ADDR_W-1:0];
      wr.en      = 1'b0;
      wr.addr    = ADDR_W'(req_index);
      wr.data    = req_entry;
      res.valid  = 1'b0;
      res.active = active_ff;

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cnt_in     = '0;
               changed_in = 1'b0;
               case (req_op)
                  OP_LOAD: begin
                     wr.en    = (int'(req_index) < TRANSITIONS);
                     state_in = RESULT;
                  end
                  OP_START: begin
                     set_in   = state_bit(start_state);
                     state_in = EPS;
                  end
                  OP_MOVE: begin
                     sym_in   = req_entry.sym;
                     set_in   = active_ff;
                     next_in  = '0;
                     state_in = MOVE;
                  end
                  default: state_in = RESULT;
               endcase
            end
         end
         MOVE: begin
            if (issue) begin
               rd.en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            if (rd_vld_ff && !rd_data.eps && rd_data.sym == sym_ff && src_hit) begin
               next_in = next_ff | dst_bit;
            end
            if (pass_end) begin
               set_in     = next_ff;
               cnt_in     = '0;
               changed_in = 1'b0;
               state_in   = EPS;
            end
         end
         EPS: begin
            if (issue) begin
               rd.en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            if (rd_vld_ff && rd_data.eps && src_hit && !(|(set_ff & dst_bit))) begin
               set_in     = set_ff | dst_bit;
               changed_in = 1'b1;
            end
            if (pass_end) begin
               cnt_in     = '0;
               changed_in = 1'b0;
               if (!changed_ff) begin
                  active_in = set_ff;
                  state_in  = RESULT;
               end
            end
         end
         RESULT: begin
            res.valid = 1'b1;
            if (res_ready) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         cnt_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         changed_ff <= 1'b0;
         active_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rd_vld_ff  <= rd.en;
         changed_ff <= changed_in;
         active_ff  <= active_in;
      end
      sym_ff  <= sym_in;
      set_ff  <= set_in;
      next_ff <= next_in;
   end

   // table is only written while no pass is reading it
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd.en && wr.en)) else $error("table read and write in the same cycle");

   // reads stay below the valid entry count
   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      rd.en |-> (cnt_ff < valid_count)) else $error("table read beyond valid count");

   // read data is consumed only in the cycle after its read
   a_rd_latency: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(rd.en)) else $error("read data valid without a read");

   // active set changes only when a run finishes
   a_active_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != EPS) |=> $stable(active_ff)) else $error("active set changed mid-run");

endmodule

// File: design/nfa_epsilon_simulator_top.sv
// top level of the nfa epsilon simulator: ports, registers, result stage
// sequence: a load item or unused op goes straight to the result; a start item runs epsilon
//   passes over the valid entries until one finds no change, a symbol item runs a move pass first
// throughput: one item at a time, the next beat can be taken once rsp_tvalid rises, while the
//   result waits in the output register; one table read port walks the valid entries
// reset: synchronous active high, clears active set and registers to zero; table is not cleared
module nfa_epsilon_simulator_top (
   input  logic                               clock,
   input  logic                               reset,
   // request beats
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // entry_index[5:0], from_state[9:6], symbol[17:10], epsilon_flag[18], to_state[22:19]
   input  logic [nfa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op[1:0]
   input  logic [nfa_pkg::OP_W-1:0]           req_tuser,
   // result beats
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // active_states[15:0], accepted[16]
   output logic [nfa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // register writes
   input  logic                               csr_we,
   input  logic [nfa_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [nfa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import nfa_pkg::*;

   // configuration registers
   logic [STATE_W-1:0]  start_ff;
   logic [STATE_W-1:0]  accept_ff;
   logic [TCOUNT_W-1:0] tcount_ff;
   logic [CNT_W-1:0]    valid_count;

   // request unpacking
   nfa_entry_type       req_entry;
   logic [IDX_W-1:0]    req_index;

   // engine to table and to output stage
   nfa_wr_type          wr;
   nfa_rd_type          rd;
   nfa_entry_type       rd_data;
   nfa_res_type         res;
   logic                res_ready;

   // output register
   logic                rsp_valid_ff;
   logic [ACTIVE_W-1:0] rsp_active_ff;
   logic                rsp_acc_ff;

   assign req_index     = req_tdata[5:0];
   assign req_entry.src = req_tdata[9:6];
   assign req_entry.sym = req_tdata[17:10];
   assign req_entry.eps = req_tdata[18];
   assign req_entry.dst = req_tdata[22:19];

   // counts above the table depth walk the whole table
   assign valid_count = (int'(tcount_ff) > TRANSITIONS) ? CNT_W'(TRANSITIONS)
                                                        : CNT_W'(tcount_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         accept_ff <= '0;
         tcount_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_START:  start_ff  <= csr_wdata[STATE_W-1:0];
            CSR_ACCEPT: accept_ff <= csr_wdata[STATE_W-1:0];
            CSR_TCOUNT: tcount_ff <= csr_wdata[TCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   nfa_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   nfa_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_index   (req_index),
      .req_entry   (req_entry),
      .start_state (start_ff),
      .valid_count (valid_count),
      .wr          (wr),
      .rd          (rd),
      .rd_data     (rd_data),
      .res         (res),
      .res_ready   (res_ready)
   );

   // output slot frees when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res.valid && res_ready) begin
         rsp_active_ff <= ACTIVE_W'(res.active);
         rsp_acc_ff    <= |(res.active & state_bit(accept_ff));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - ACTIVE_W - 1)'(0), rsp_acc_ff, rsp_active_ff};

endmodule

// File: test/nfa_checker.sv
// scoreboard for the nfa epsilon simulator: mirrors the automaton and checks every result beat
module nfa_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // entry_index[5:0], from_state[9:6], symbol[17:10], epsilon_flag[18], to_state[22:19]
   input  logic [nfa_pkg::REQ_DATA_W-1:0] req_tdata,
   // op[1:0]
   input  logic [nfa_pkg::OP_W-1:0]       req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // active_states[15:0], accepted[16]
   input  logic [nfa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [nfa_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [nfa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatches,
   output int                             pending,
   output int                             accept_hits
);
   timeunit 1ns;
   timeprecision 1ps;
   import nfa_pkg::*;

   typedef struct packed {
      logic                acc;
      logic [ACTIVE_W-1:0] active;
   } nfa_view_type;

   nfa_entry_type       arc_table [TRANSITIONS];
   logic [STATES-1:0]   live_set   = '0;
   logic [STATE_W-1:0]  start_idx  = '0;
   logic [STATE_W-1:0]  accept_idx = '0;
   logic [TCOUNT_W-1:0] arc_total  = '0;
   nfa_view_type        awaited_q [$];
   int                  awaited_size = 0;
   int                  bad_count    = 0;
   int                  hit_count    = 0;

   assign mismatches  = bad_count;
   assign pending     = awaited_size;
   assign accept_hits = hit_count;

   // counts above the table size clamp to the table size
   function automatic int arcs_in_use();
      return (int'(arc_total) > TRANSITIONS) ? TRANSITIONS : int'(arc_total);
   endfunction

   // repeat epsilon passes in table order until nothing new turns on
   function automatic logic [STATES-1:0] eps_reach(input logic [STATES-1:0] set);
      logic [STATES-1:0] prev;
      int                n;
      n = arcs_in_use();
      do begin
         prev = set;
         for (int i = 0; i < n; i++) begin
            if (arc_table[i].eps && set[arc_table[i].src]) set[arc_table[i].dst] = 1'b1;
         end
      end while (set != prev);
      return set;
   endfunction

   // epsilon entries never match a symbol, whatever their symbol code
   function automatic logic [STATES-1:0] symbol_move(input logic [STATES-1:0] set,
                                                     input logic [SYM_W-1:0]  sym);
      logic [STATES-1:0] next_set;
      int                n;
      next_set = '0;
      n = arcs_in_use();
      for (int i = 0; i < n; i++) begin
         if (!arc_table[i].eps && arc_table[i].sym == sym && set[arc_table[i].src])
            next_set[arc_table[i].dst] = 1'b1;
      end
      return next_set;
   endfunction

   always @(posedge clock) begin
      nfa_view_type  want;
      nfa_view_type  got;
      nfa_entry_type arc;
      if (reset) begin
         live_set   = '0;
         start_idx  = '0;
         accept_idx = '0;
         arc_total  = '0;
         awaited_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_START:  start_idx  = csr_wdata[STATE_W-1:0];
               CSR_ACCEPT: accept_idx = csr_wdata[STATE_W-1:0];
               CSR_TCOUNT: arc_total  = csr_wdata[TCOUNT_W-1:0];
               default: ;
            endcase
         end
         // results first, so a beat never meets an expectation pushed at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.active = rsp_tdata[ACTIVE_W-1:0];
            got.acc    = rsp_tdata[ACTIVE_W];
            if (got.acc === 1'b1) hit_count++;
            if (awaited_q.size() == 0) begin
               if (bad_count < 10)
                  $display("%0t mismatch: result beat active=%h accepted=%b with none expected",
                           $realtime, got.active, got.acc);
               bad_count++;
            end else begin
               want = awaited_q.pop_front();
               if (got.active !== want.active || got.acc !== want.acc) begin
                  if (bad_count < 10)
                     $display("%0t mismatch: active exp %h got %h, accepted exp %b got %b",
                              $realtime, want.active, got.active, want.acc, got.acc);
                  bad_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_LOAD: begin
                  arc.src = req_tdata[9:6];
                  arc.sym = req_tdata[17:10];
                  arc.eps = req_tdata[18];
                  arc.dst = req_tdata[22:19];
                  arc_table[req_tdata[5:0]] = arc;
               end
               OP_START: begin
                  live_set = '0;
                  live_set[start_idx] = 1'b1;
                  live_set = eps_reach(live_set);
               end
               OP_MOVE: live_set = eps_reach(symbol_move(live_set, req_tdata[17:10]));
               default: ;
            endcase
            want.active = live_set;
            want.acc    = live_set[accept_idx];
            awaited_q.push_back(want);
         end
      end
      awaited_size = awaited_q.size();
   end

endmodule

// File: test/tb_top.sv
// testbench top for the nfa epsilon simulator: stimulus, handshake pacing, watchdog and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import nfa_pkg::*;

   localparam int ITEM_TARGET = 1150;
   // worst item: 17 passes over the full table plus both sides' longest waits, taken ~5x
   localparam int QUIET_LIMIT = 6000;
   // quiet stretch after the last result so a stray beat still shows up
   localparam int TAIL_CYCLES = 40;
   // the one op code the block has no use for
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int mismatches;
   int pending;
   int accept_hits;

   nfa_epsilon_simulator_top i_dut (.*);

   nfa_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // bookkeeping for the stimulus side
   // ---------------------------------------------------------------------------
   bit               written [TRANSITIONS];  // slots loaded at least once
   logic [SYM_W-1:0] alphabet [4];            // symbols the current automaton uses
   bit               tx_calm     = 1'b0;      // sender runs back to back while set
   int               items_sent  = 0;
   int               op_seen [4] = '{0, 0, 0, 0};
   int               settings    = 0;
   int               max_total   = 0;

   // ---------------------------------------------------------------------------
   // result side: random stall before each result, with calm stretches
   // ---------------------------------------------------------------------------
   logic rsp_beat_seen = 1'b0;
   int   rsp_hold      = 0;
   bit   rx_calm       = 1'b0;

   always @(posedge clock) rsp_beat_seen <= rsp_tvalid && rsp_tready;

   always @(negedge clock) begin
      if (rsp_beat_seen) begin
         if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
         rsp_hold = rx_calm ? 0 : $urandom_range(0, 5);
      end
      // the stall only counts down while a result is actually offered
      if (rsp_hold > 0) begin
         if (rsp_tvalid) rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: any beat or register write counts as progress
   // ---------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, pending);
         $display("FAIL nfa_epsilon_simulator_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // one beat: random gap with garbage on the bus, then hold until taken
   task automatic send_item(input logic [OP_W-1:0] op, input logic [REQ_DATA_W-1:0] data);
      int gap;
      if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_DATA_W'($urandom);
         req_tuser  <= OP_W'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      op_seen[op]++;
   endtask

   task automatic load_entry(input int idx, input logic [STATE_W-1:0] src,
                             input logic [SYM_W-1:0] sym, input logic eps,
                             input logic [STATE_W-1:0] dst);
      send_item(OP_LOAD, {1'b0, dst, eps, sym, src, IDX_W'(idx)});
      written[idx] = 1'b1;
   endtask

   // mostly symbols of the current alphabet so moves actually fire
   task automatic load_random(input int idx);
      logic [SYM_W-1:0] sym;
      sym = ($urandom_range(0, 9) == 0) ? SYM_W'($urandom) : alphabet[$urandom_range(0, 3)];
      load_entry(idx, STATE_W'($urandom), sym, $urandom_range(0, 3) == 0,
                 STATE_W'($urandom));
   endtask

   // fields a symbol item does not use carry noise
   task automatic consume(input logic [SYM_W-1:0] sym);
      logic [REQ_DATA_W-1:0] data;
      data = {1'b0, 23'($urandom)};
      data[17:10] = sym;
      send_item(OP_MOVE, data);
   endtask

   task automatic send_plain(input logic [OP_W-1:0] op);
      send_item(op, {1'b0, 23'($urandom)});
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic configure(input int start_st, input int accept_st, input int total);
      write_reg(CSR_START, start_st);
      write_reg(CSR_ACCEPT, accept_st);
      write_reg(CSR_TCOUNT, total);
      settings++;
      if (total > max_total) max_total = total;
   endtask

   // drop valid and wait until every result is back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int pick;
      int total;
      int in_use;
      int roll;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // empty table, registers at reset: symbol before any start, then start on state 0
      consume(8'hFF);
      send_plain(OP_START);
      send_plain(OP_NONE);
      drain();

      // top state as both start and accept, still no valid entries
      configure(15, 15, 0);
      send_plain(OP_START);

      // small automaton: a reverse-ordered epsilon chain 0->1->2->3->4 needs several
      // passes, and an epsilon entry whose code matches a real input symbol
      load_entry(0, 4'd15, 8'hFF, 1'b0, 4'd0);
      load_entry(1, 4'd3,  8'h00, 1'b1, 4'd4);
      load_entry(2, 4'd2,  8'h00, 1'b1, 4'd3);
      load_entry(3, 4'd1,  8'h00, 1'b1, 4'd2);
      load_entry(4, 4'd0,  8'h00, 1'b1, 4'd1);
      load_entry(5, 4'd13, 8'h55, 1'b1, 4'd7);
      load_entry(6, 4'd0,  8'h00, 1'b0, 4'd15);
      load_entry(7, 4'd4,  8'h55, 1'b0, 4'd13);
      load_entry(63, 4'd15, 8'hFF, 1'b1, 4'd15);
      drain();
      configure(15, 4, 8);
      send_plain(OP_START);
      consume(8'h00);
      consume(8'hFF);
      consume(8'h55);
      consume(8'h55);
      send_plain(OP_NONE);

      // random phases: new registers, make sure every used slot is loaded, then runs
      while (items_sent < ITEM_TARGET) begin
         drain();
         pick = $urandom_range(0, 9);
         case (pick)
            0:       total = TRANSITIONS;
            1:       total = $urandom_range(TRANSITIONS + 1, 127);
            2:       total = 127;
            3, 4:    total = $urandom_range(17, TRANSITIONS - 1);
            default: total = $urandom_range(0, 16);
         endcase
         configure($urandom_range(0, 15), $urandom_range(0, 15), total);
         in_use = (total > TRANSITIONS) ? TRANSITIONS : total;
         for (int i = 0; i < 4; i++) alphabet[i] = SYM_W'($urandom);

         // unloaded slots below the count must never be read
         for (int i = 0; i < in_use; i++) begin
            if (!written[i] || $urandom_range(0, (in_use > 16) ? 7 : 1) == 0) load_random(i);
         end

         repeat ($urandom_range(1, 3)) begin
            // now and then carry the old set over instead of restarting
            if ($urandom_range(0, 9) != 0) send_plain(OP_START);
            repeat ($urandom_range(3, 12)) begin
               roll = $urandom_range(0, 19);
               if (roll < 16)       consume(alphabet[$urandom_range(0, 3)]);
               else if (roll < 18)  consume(SYM_W'($urandom));
               else if (roll == 18) send_plain(OP_NONE);
               else                 load_random($urandom_range(0, TRANSITIONS - 1));
            end
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d load, %0d start, %0d symbol and %0d unused-op beats",
               op_seen[OP_LOAD], op_seen[OP_START], op_seen[OP_MOVE], op_seen[OP_NONE]);
      $display("over %0d register settings (table count up to %0d), %0d results accepting",
               settings, max_total, accept_hits);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS nfa_epsilon_simulator_top");
      end else begin
         $display("FAIL nfa_epsilon_simulator_top");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/nfa_pkg.sv
design/nfa_table.sv
design/nfa_engine.sv
design/nfa_epsilon_simulator_top.sv
test/nfa_checker.sv
test/tb_top.sv
